// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/prbc_pkg.sv -----
`timescale 1ns / 1ps

package prbc_pkg;

  localparam int unsigned OpW        = 2;
  localparam int unsigned IndexW     = 3;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned HoldW      = 16;
  localparam int unsigned MaskW      = 8;

  localparam int unsigned RelayCountDef = 8;

  localparam logic [HoldW-1:0] HoldTimeReset = 16'd10000;

  typedef enum logic [OpW-1:0] {
    OP_PUSH    = 2'd0,
    OP_LONG    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_POLL    = 2'd3
  } op_e;

endpackage

// ----- rtl/prbc_if.sv -----
`timescale 1ns / 1ps

// Event channel: one button event or poll per word.
interface prbc_in_if;
  logic                            valid;
  logic                            ready;
  logic [prbc_pkg::OpW-1:0]        op;
  logic [prbc_pkg::IndexW-1:0]     relay_index;
  logic [prbc_pkg::TimeW-1:0]      now_ms;

  modport source (output valid, op, relay_index, now_ms, input ready);
  modport sink   (input valid, op, relay_index, now_ms, output ready);
endinterface

// Result channel: relay mask and expiry flag.
interface prbc_out_if;
  logic                            valid;
  logic                            ready;
  logic [prbc_pkg::MaskW-1:0]      active_mask;
  logic                            expired;

  modport source (output valid, active_mask, expired, input ready);
  modport sink   (input valid, active_mask, expired, output ready);
endinterface

// Hold time write channel.
interface prbc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [prbc_pkg::HoldW-1:0]      hold_time_ms;

  modport source (output valid, hold_time_ms, input ready);
  modport sink   (input valid, hold_time_ms, output ready);
endinterface

// ----- rtl/paired_relay_button_controller.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Paired relay button controller. Relays i and i^1 form an opposing pair
// (up/down of one blind); switching one on switches its partner off. Each
// event word carries an op (push, long press, release, poll), a relay index
// and the current millisecond time. A push toggles the relay and stamps the
// time when it turns on; a long press turns it on and marks it held; a
// release drops a held relay; a poll drops an unheld relay whose age
// (now - stamp, modulo 2^32) is strictly above hold_time_ms. Every event
// word yields exactly one result word: the mask of relays 0..7 after the
// event and an expiry flag. Indexes at or above RelayCount leave the state
// alone. Throughput is one event per cycle while out_o.ready stays high; an
// event passes the input register, then the result register, with the relay
// state read, updated and written back as the result register loads.
// hold_time_ms is taken from the cfg channel (always ready) and should only
// change while no event is in flight.
module paired_relay_button_controller #(
  parameter int unsigned RelayCount = prbc_pkg::RelayCountDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  prbc_in_if.sink        in_i,
  prbc_out_if.source     out_o,
  prbc_cfg_if.sink       cfg_i
);

  // Index widths: SelW addresses the bank, ExtW also holds RelayCount itself
  // so the range check never overflows.
  localparam int unsigned SelW = $clog2(RelayCount);
  localparam int unsigned ExtW =
    ((SelW > prbc_pkg::IndexW) ? SelW : prbc_pkg::IndexW) + 1;

  // Hold time register.
  logic [prbc_pkg::HoldW-1:0] hold_q;

  // Input register.
  logic                          s1_valid_q, s1_valid_d;
  prbc_pkg::op_e                 op_q;
  logic [prbc_pkg::IndexW-1:0]   idx_q;
  logic [prbc_pkg::TimeW-1:0]    now_q;

  // Relay state.
  logic [RelayCount-1:0]         on_q, on_d;
  logic [RelayCount-1:0]         held_q, held_d;
  logic [prbc_pkg::TimeW-1:0]    stamp_q [RelayCount];

  // Result register.
  logic                          out_valid_q;
  logic [prbc_pkg::MaskW-1:0]    mask_q, mask_d;
  logic                          expired_q, expired_d;

  // Handshake.
  logic                          adv;
  logic                          proc;
  logic                          in_acc;

  // Datapath.
  logic [ExtW-1:0]               ext;
  logic [ExtW-1:0]               mate_ext;
  logic [SelW-1:0]               sel;
  logic                          idx_ok;
  logic                          cur_on;
  logic                          cur_held;
  logic [prbc_pkg::TimeW-1:0]    age;
  logic                          over;
  logic                          clr_mate;
  logic                          wr_stamp;

  // Advance the result stage when it is empty or being drained; the input
  // register moves on whenever the result stage does.
  assign adv        = !out_valid_q || out_o.ready;
  assign proc       = s1_valid_q && adv;
  assign in_i.ready = !s1_valid_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign s1_valid_d = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_q);

  assign cfg_i.ready = 1'b1;

  // Decode the relay and its partner.
  assign ext      = ExtW'(idx_q);
  assign mate_ext = ext ^ ExtW'(1);
  assign sel      = ext[SelW-1:0];
  assign idx_ok   = ext < ExtW'(RelayCount);

  assign cur_on   = on_q[sel];
  assign cur_held = held_q[sel];
  assign age      = now_q - stamp_q[sel];
  assign over     = age > {{(prbc_pkg::TimeW - prbc_pkg::HoldW){1'b0}}, hold_q};

  // Read-modify-write of the addressed relay.
  always_comb begin
    on_d      = on_q;
    held_d    = held_q;
    clr_mate  = 1'b0;
    wr_stamp  = 1'b0;
    expired_d = 1'b0;
    if (proc && idx_ok) begin
      case (op_q)
        prbc_pkg::OP_PUSH: begin
          if (cur_on) begin
            on_d[sel] = 1'b0;
          end else begin
            // Switch on: drop the partner first, stamp the time.
            on_d[sel] = 1'b1;
            clr_mate  = 1'b1;
            wr_stamp  = 1'b1;
          end
        end
        prbc_pkg::OP_LONG: begin
          if (!cur_on) begin
            on_d[sel] = 1'b1;
            clr_mate  = 1'b1;
          end
          held_d[sel] = 1'b1;
        end
        prbc_pkg::OP_RELEASE: begin
          if (cur_held) begin
            on_d[sel]   = 1'b0;
            held_d[sel] = 1'b0;
          end
        end
        prbc_pkg::OP_POLL: begin
          if (cur_on && !cur_held && over) begin
            on_d[sel] = 1'b0;
            expired_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // Partner off; an odd last relay simply has no match here.
    for (int i = 0; i < RelayCount; i++) begin
      if (clr_mate && (mate_ext == ExtW'(i))) begin
        on_d[i] = 1'b0;
      end
    end
  end

  // Only relays 0..7 are visible in the mask.
  for (genvar j = 0; j < prbc_pkg::MaskW; j++) begin : g_mask
    if (j < RelayCount) begin : g_bit
      assign mask_d[j] = on_d[j];
    end else begin : g_none
      assign mask_d[j] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= prbc_pkg::HoldTimeReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      on_q        <= '0;
      held_q      <= '0;
      for (int i = 0; i < RelayCount; i++) begin
        stamp_q[i] <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        hold_q <= cfg_i.hold_time_ms;
      end
      s1_valid_q <= s1_valid_d;
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      on_q   <= on_d;
      held_q <= held_d;
      if (wr_stamp) begin
        stamp_q[sel] <= now_q;
      end
    end
  end

  // Payload registers: the input side captures on accept, the result side on processing; both hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= prbc_pkg::op_e'(in_i.op);
      idx_q <= in_i.relay_index;
      now_q <= in_i.now_ms;
    end
    if (proc) begin
      mask_q    <= mask_d;
      expired_q <= expired_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.active_mask = mask_q;
  assign out_o.expired     = expired_q;

  // The first pair is never on together.
  `ASSERT_SAME(a_pair_exclusive, clk_i, rst_ni, 1'b1, !(on_q[0] && on_q[1]))

  // An expiry leaves the relay off.
  `ASSERT_NEXT(a_expiry_off, clk_i, rst_ni, proc && expired_d, !on_q[$past(sel)])

  // A long press leaves the relay on and held.
  `ASSERT_NEXT(a_long_held, clk_i, rst_ni,
    proc && idx_ok && (op_q == prbc_pkg::OP_LONG),
    on_q[$past(sel)] && held_q[$past(sel)])

endmodule

// ----- dv/paired_relay_button_controller_tb.sv -----
`timescale 1ns / 1ps

module paired_relay_button_controller_tb;
  import prbc_pkg::*;

  localparam int unsigned StallLimit = 2000;  // cycles with no word moving anywhere
  localparam int unsigned HoldOffCycles = 300;

  // One expected result word: mask of relays 0..7 plus the timeout flag.
  typedef struct packed {
    logic [MaskW-1:0] active_mask;
    logic             expired;
  } relay_result_t;

  // Mirror of the relay bank. Update it on every accepted event word and
  // queue the result word the block must return for it.
  class relay_pair_tracker;
    bit                  on_q[RelayCountDef];
    bit                  held_q[RelayCountDef];
    logic [TimeW-1:0]    stamp_q[RelayCountDef];
    logic [HoldW-1:0]    hold_ms;
    relay_result_t       pending_results[$];
    int unsigned         errors;

    function new();
      foreach (on_q[i]) begin
        on_q[i] = 1'b0;
        held_q[i] = 1'b0;
        stamp_q[i] = '0;
      end
      hold_ms = HoldTimeReset;
      errors = 0;
    endfunction

    function void set_hold(logic [HoldW-1:0] value);
      hold_ms = value;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Turn a relay on; drop its partner first when the partner exists.
    function void energize(int unsigned r);
      if (!on_q[r]) begin
        if ((r ^ 1) < RelayCountDef) on_q[r ^ 1] = 1'b0;
        on_q[r] = 1'b1;
      end
    endfunction

    function void note_event(op_e op, logic [IndexW-1:0] idx, logic [TimeW-1:0] now);
      relay_result_t    res;
      logic [TimeW-1:0] age;
      res.expired = 1'b0;
      res.active_mask = '0;
      if (idx < RelayCountDef) begin
        case (op)
          OP_PUSH: begin
            if (on_q[idx]) begin
              on_q[idx] = 1'b0;   // held mark stays as it is
            end else begin
              energize(idx);
              stamp_q[idx] = now;
            end
          end
          OP_LONG: begin
            energize(idx);         // never writes a new stamp
            held_q[idx] = 1'b1;
          end
          OP_RELEASE: begin
            if (held_q[idx]) begin
              on_q[idx] = 1'b0;
              held_q[idx] = 1'b0;
            end
          end
          default: begin
            // Age wraps modulo 2^32; expire only when strictly above the hold time.
            age = now - stamp_q[idx];
            if (on_q[idx] && !held_q[idx] && age > TimeW'(hold_ms)) begin
              on_q[idx] = 1'b0;
              res.expired = 1'b1;
            end
          end
        endcase
      end
      for (int unsigned i = 0; i < RelayCountDef && i < MaskW; i++) begin
        res.active_mask[i] = on_q[i];
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [MaskW-1:0] mask, logic expired);
      relay_result_t want;
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: active_mask %h expired %b", mask, expired);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (mask !== want.active_mask) begin
        $error("active_mask: expected %h, actual %h", want.active_mask, mask);
        errors++;
      end
      if (expired !== want.expired) begin
        $error("expired: expected %b, actual %b", want.expired, expired);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic rx_hold = 1'b0;          // forces the result side to hold off
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [TimeW-1:0] time_base = '0;

  relay_pair_tracker relays = new();

  prbc_in_if  in_if ();
  prbc_out_if out_if ();
  prbc_cfg_if cfg_if ();

  paired_relay_button_controller DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: sample the handshake as it stood before the edge, then pick
  // ready for the next cycle. Hold ready low while a hold-off is running.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        relays.check_result(out_if.active_mask, out_if.expired);
      end
      out_if.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long.
  initial begin
    int unsigned stall;
    stall = 0;
    while (stall < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // Offer one event word, hold it until accepted, then note it and maybe idle.
  task automatic send_event(input op_e op, input logic [IndexW-1:0] idx,
                            input logic [TimeW-1:0] now);
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.relay_index <= idx;
    in_if.now_ms <= now;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    relays.note_event(op, idx, now);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Write the hold time; call only while nothing is in flight.
  task automatic write_hold(input logic [HoldW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.hold_time_ms <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    relays.set_hold(value);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every expected result word has come back, plus a short margin.
  task automatic drain();
    while (relays.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly a steadily advancing clock so that polls hit and miss the hold
  // time; some words jump toward the wrap point, some carry a random time.
  task automatic run_random(input int unsigned count);
    op_e              op;
    logic [IndexW-1:0] idx;
    logic [TimeW-1:0] now;
    int unsigned      roll;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 35) op = OP_PUSH;
      else if (roll < 50) op = OP_LONG;
      else if (roll < 65) op = OP_RELEASE;
      else op = OP_POLL;
      idx = IndexW'($urandom_range(RelayCountDef - 1));
      roll = $urandom_range(99);
      if (roll < 85) begin
        time_base = time_base + $urandom_range(20000);
        now = time_base;
      end else if (roll < 90) begin
        time_base = 32'hFFFF_FFFF - $urandom_range(30000);
        now = time_base;
      end else begin
        now = $urandom;
      end
      send_event(op, idx, now);
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.op <= OP_PUSH;
    in_if.relay_index <= '0;
    in_if.now_ms <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.hold_time_ms <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles about a third of the time, receiver about half.
    send_idle_pct = 37;
    recv_idle_pct = 54;

    // Directed words under the reset hold time of 10000 ms.
    send_event(OP_PUSH,    3'd0, 32'd0);           // relay 0 on
    send_event(OP_PUSH,    3'd1, 32'd100);         // partner takes over
    send_event(OP_POLL,    3'd1, 32'd10100);       // age equals hold: stays on
    send_event(OP_POLL,    3'd1, 32'd10101);       // one past hold: expires
    send_event(OP_LONG,    3'd7, 32'hFFFF_FFFF);   // held on
    send_event(OP_POLL,    3'd7, 32'd0);           // held relays never time out
    send_event(OP_PUSH,    3'd6, 32'd5);           // drop held partner, mark stays
    send_event(OP_RELEASE, 3'd7, 32'd6);           // clear mark on a relay already off
    send_event(OP_PUSH,    3'd7, 32'hFFFF_FFF0);   // stamp just before the wrap
    send_event(OP_POLL,    3'd7, 32'h0000_2700);   // wrapped age equals hold
    send_event(OP_POLL,    3'd7, 32'h0000_2701);   // wrapped age one past hold
    send_event(OP_PUSH,    3'd2, 32'h1234_5678);
    send_event(OP_LONG,    3'd2, 32'h9999_9999);   // already on: stamp kept, mark set
    send_event(OP_POLL,    3'd2, 32'hF000_0000);   // held: no timeout
    send_event(OP_PUSH,    3'd2, 32'hF000_0001);   // push off, mark left set
    send_event(OP_RELEASE, 3'd2, 32'hF000_0002);
    send_event(OP_RELEASE, 3'd3, 32'h5555_5555);   // not held: nothing happens
    send_event(OP_POLL,    3'd4, 32'hAAAA_AAAA);   // relay off: nothing happens
    send_event(OP_PUSH,    3'd4, 32'h8000_0000);
    send_event(OP_PUSH,    3'd5, 32'h7FFF_FFFF);
    send_event(OP_POLL,    3'd5, 32'hFFFF_FFFF);   // half-range age
    send_event(OP_LONG,    3'd0, 32'd0);
    send_event(OP_LONG,    3'd1, 32'd1);           // held partner dropped
    send_event(OP_RELEASE, 3'd0, 32'd2);
    send_event(OP_RELEASE, 3'd1, 32'd3);
    in_if.valid <= 1'b0;
    drain();

    // Top of the usual range; stall the result side long enough to back up
    // the pipeline while the sender keeps offering words.
    write_hold(16'd60000);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    run_random(200);
    drain();

    // Swap the idle rates; zero hold time expires anything at least 1 ms old.
    send_idle_pct = 54;
    recv_idle_pct = 37;
    write_hold(16'd0);
    run_random(200);
    drain();

    // Full throughput from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_hold(16'hFFFF);
    run_random(200);
    drain();

    write_hold(16'($urandom_range(10000, 60000)));
    run_random(100);
    drain();

    write_hold(16'd10000);
    run_random(100);
    drain();
    repeat (8) @(posedge clk_i);

    if (relays.pending() != 0) begin
      $error("%0d result words never arrived", relays.pending());
    end
    if (relays.errors == 0 && relays.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- paired_relay_button_controller.f -----
+incdir+rtl
rtl/prbc_pkg.sv
rtl/prbc_if.sv
rtl/paired_relay_button_controller.sv
dv/paired_relay_button_controller_tb.sv
